FILE: design/pcs_pkg.sv
// shared types, constants and microprogram of the pid controller step block
package pcs_pkg;

  localparam int INPUT_BITS_DEF = 16;
  localparam int GAIN_W         = 16;
  localparam int LIMIT_W        = 30;
  localparam int WORD_W         = 32;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 32;
  localparam int UPC_W          = 3;
  localparam int ISHIFT         = 3;

  localparam logic [CFG_IDX_W-1:0] REG_P_GAIN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_I_GAIN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_D_GAIN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_I_LIMIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_MIN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_MAX = 3'd5;

  localparam logic [LIMIT_W-1:0] I_LIMIT_RST = 30'd1048575;
  localparam logic [WORD_W-1:0]  OUT_MIN_RST = 32'h8000_0000;
  localparam logic [WORD_W-1:0]  OUT_MAX_RST = 32'h7fff_ffff;

  typedef enum logic [2:0] {
    OP_LOAD  = 3'd0,
    OP_MUL_I = 3'd1,
    OP_ITERM = 3'd2,
    OP_MUL_D = 3'd3,
    OP_DTERM = 3'd4,
    OP_MUL_P = 3'd5,
    OP_CLAMP = 3'd6
  } op_t;

  typedef enum logic [1:0] {
    COND_NEXT     = 2'd0,
    COND_ALWAYS   = 2'd1,
    COND_NO_IN    = 2'd2,
    COND_OUT_BUSY = 2'd3
  } cond_t;

  typedef struct packed {
    op_t              op;
    cond_t            cond;
    logic [UPC_W-1:0] target;
  } uword_t;

  typedef struct packed {
    op_t  op;
    logic go;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic out_busy;
  } stat_t;

  function automatic uword_t rom_word(input logic [UPC_W-1:0] addr);
    uword_t w;
    unique case (addr)
      3'd0:    w = '{op: OP_LOAD,  cond: COND_NO_IN,    target: 3'd0};
      3'd1:    w = '{op: OP_MUL_I, cond: COND_NEXT,     target: 3'd0};
      3'd2:    w = '{op: OP_ITERM, cond: COND_NEXT,     target: 3'd0};
      3'd3:    w = '{op: OP_MUL_D, cond: COND_NEXT,     target: 3'd0};
      3'd4:    w = '{op: OP_DTERM, cond: COND_NEXT,     target: 3'd0};
      3'd5:    w = '{op: OP_MUL_P, cond: COND_NEXT,     target: 3'd0};
      3'd6:    w = '{op: OP_CLAMP, cond: COND_OUT_BUSY, target: 3'd6};
      default: w = '{op: OP_LOAD,  cond: COND_ALWAYS,   target: 3'd0};
    endcase
    return w;
  endfunction

endpackage

FILE: design/pcs_intf.sv
// channel interfaces: sample beats, result beats and register writes
interface pcs_sample_if #(
  parameter int W = pcs_pkg::INPUT_BITS_DEF
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] target;
  logic signed [W-1:0] measured;

  modport source (output valid, output target, output measured, input ready);
  modport sink   (input valid, input target, input measured, output ready);
endinterface

interface pcs_result_if;
  logic                               valid;
  logic                               ready;
  logic signed [pcs_pkg::WORD_W-1:0]  drive;

  modport source (output valid, output drive, input ready);
  modport sink   (input valid, input drive, output ready);
endinterface

interface pcs_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [pcs_pkg::CFG_IDX_W-1:0]     index;
  logic [pcs_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: design/pid_controller_step.sv
// top level: integer pid controller, one drive beat per sample beat
//
//  channel  dir  beat contents
//  sample   in   target, measured (INPUT_BITS each, signed)
//  result   out  drive (32 bit signed)
//  cfg      in   index (3 bit), data (32 bit); always ready
//
// each sample passes through one load step and six microcode steps; three of
// them (integral, derivative, proportional) share one 16 x 32 multiplier.
// sample is ready only at the load step; the final step holds while the
// output register still has a beat not taken, so a stall stretches the item.
// reset clears the step counter, the accumulator, the prior error and the
// registers to their reset values; no clearing pass is needed.
module pid_controller_step #(
  parameter int INPUT_BITS = pcs_pkg::INPUT_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  pcs_sample_if.sink    sample,
  pcs_result_if.source  result,
  pcs_cfg_if.sink       cfg
);
  import pcs_pkg::*;

  localparam int EW = INPUT_BITS + 1;

  logic [GAIN_W-1:0]        p_gain;
  logic [GAIN_W-1:0]        i_gain;
  logic [GAIN_W-1:0]        d_gain;
  logic [LIMIT_W-1:0]       i_limit;
  logic signed [WORD_W-1:0] out_min;
  logic signed [WORD_W-1:0] out_max;

  logic signed [WORD_W-1:0] error_sum;
  logic signed [EW-1:0]     prior_error;
  logic signed [EW-1:0]     err;
  logic [WORD_W-1:0]        prod;
  logic [WORD_W-1:0]        sum;
  logic signed [WORD_W-1:0] drive;
  logic                     out_full;

  ctrl_t ctrl;
  stat_t stat;

  logic signed [EW-1:0]         err_new;
  logic [WORD_W-1:0]            err_ext;
  logic signed [EW:0]           diff;
  logic [WORD_W-1:0]            diff_ext;
  logic signed [WORD_W:0]       acc;
  logic signed [WORD_W:0]       lim;
  logic signed [WORD_W-1:0]     acc_clamped;
  logic [GAIN_W-1:0]            mul_a;
  logic [WORD_W-1:0]            mul_b;
  logic [GAIN_W+WORD_W-1:0]     mul_full;
  logic signed [WORD_W-1:0]     iterm;
  logic signed [WORD_W-1:0]     drive_clamped;

  pcs_useq u_useq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctrl (ctrl)
  );

  assign stat.in_valid = sample.valid;
  assign stat.out_busy = out_full && !result.ready;

  assign sample.ready = (ctrl.op == OP_LOAD);
  assign cfg.ready    = 1'b1;
  assign result.valid = out_full;
  assign result.drive = drive;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      p_gain  <= '0;
      i_gain  <= '0;
      d_gain  <= '0;
      i_limit <= I_LIMIT_RST;
      out_min <= OUT_MIN_RST;
      out_max <= OUT_MAX_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_P_GAIN:  p_gain  <= cfg.data[GAIN_W-1:0];
        REG_I_GAIN:  i_gain  <= cfg.data[GAIN_W-1:0];
        REG_D_GAIN:  d_gain  <= cfg.data[GAIN_W-1:0];
        REG_I_LIMIT: i_limit <= cfg.data[LIMIT_W-1:0];
        REG_OUT_MIN: out_min <= cfg.data;
        REG_OUT_MAX: out_max <= cfg.data;
        default: ;
      endcase
    end
  end

  // datapath operands
  assign err_new  = EW'(sample.target) - EW'(sample.measured);
  assign err_ext  = WORD_W'(err);
  assign diff     = (EW+1)'(err) - (EW+1)'(prior_error);
  assign diff_ext = WORD_W'(diff);

  assign acc = (WORD_W+1)'(error_sum) + (WORD_W+1)'(err);
  assign lim = (WORD_W+1)'({1'b0, i_limit});

  always_comb begin
    if (acc > lim) begin
      acc_clamped = WORD_W'(lim);
    end else if (acc < -lim) begin
      acc_clamped = WORD_W'(-lim);
    end else begin
      acc_clamped = WORD_W'(acc);
    end
  end

  always_comb begin
    unique case (ctrl.op)
      OP_MUL_I: begin
        mul_a = i_gain;
        mul_b = err_ext + error_sum;
      end
      OP_MUL_D: begin
        mul_a = d_gain;
        mul_b = diff_ext;
      end
      default: begin
        mul_a = p_gain;
        mul_b = sum;
      end
    endcase
  end

  assign mul_full = mul_a * mul_b;
  assign iterm    = $signed(prod) >>> ISHIFT;

  // out_max is tested first
  always_comb begin
    if ($signed(prod) > out_max) begin
      drive_clamped = out_max;
    end else if ($signed(prod) < out_min) begin
      drive_clamped = out_min;
    end else begin
      drive_clamped = $signed(prod);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      error_sum   <= '0;
      prior_error <= '0;
    end else if (ctrl.go) begin
      unique case (ctrl.op)
        OP_ITERM: error_sum   <= acc_clamped;
        OP_MUL_D: prior_error <= err;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.go) begin
      unique case (ctrl.op)
        OP_LOAD:  err   <= err_new;
        OP_MUL_I: prod  <= mul_full[WORD_W-1:0];
        OP_ITERM: sum   <= err_ext + iterm;
        OP_MUL_D: prod  <= mul_full[WORD_W-1:0];
        OP_DTERM: sum   <= sum + prod;
        OP_MUL_P: prod  <= mul_full[WORD_W-1:0];
        OP_CLAMP: drive <= drive_clamped;
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (ctrl.go && ctrl.op == OP_CLAMP) begin
      out_full <= 1'b1;
    end else if (result.ready) begin
      out_full <= 1'b0;
    end
  end

endmodule

FILE: design/pcs_useq.sv
// micro-sequencer: step counter, program rom and conditional jumps
module pcs_useq (
  input  logic            clk,
  input  logic            rst,
  input  pcs_pkg::stat_t  stat,
  output pcs_pkg::ctrl_t  ctrl
);
  import pcs_pkg::*;

  logic [UPC_W-1:0] upc;
  logic [UPC_W-1:0] upc_next;
  uword_t           cw;
  logic             jump;

  assign cw = rom_word(upc);

  always_comb begin
    unique case (cw.cond)
      COND_NEXT:     jump = 1'b0;
      COND_ALWAYS:   jump = 1'b1;
      COND_NO_IN:    jump = !stat.in_valid;
      COND_OUT_BUSY: jump = stat.out_busy;
      default:       jump = 1'b0;
    endcase
  end

  // the last step returns to the start once its beat is written
  always_comb begin
    if (jump) begin
      upc_next = cw.target;
    end else if (cw.op == OP_CLAMP) begin
      upc_next = '0;
    end else begin
      upc_next = upc + 1'b1;
    end
  end

  assign ctrl.op = cw.op;
  assign ctrl.go = !jump;

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= '0;
    end else begin
      upc <= upc_next;
    end
  end

endmodule

FILE: sim/pcs_drive_checker.sv
// checker for the pid controller step block: predicts each drive beat and compares
`timescale 1ns / 1ps

module pcs_drive_checker
  import pcs_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_valid,
  input  logic                      s_ready,
  input  logic signed [15:0]        s_target,
  input  logic signed [15:0]        s_measured,
  input  logic                      r_valid,
  input  logic                      r_ready,
  input  logic signed [WORD_W-1:0]  r_drive,
  input  logic                      c_valid,
  input  logic                      c_ready,
  input  logic [CFG_IDX_W-1:0]      c_index,
  input  logic [CFG_DATA_W-1:0]     c_data,
  output int                        mismatches,
  output int                        pending
);

  logic [GAIN_W-1:0]         kp, ki, kd;
  logic [LIMIT_W-1:0]        i_lim;
  logic signed [WORD_W-1:0]  out_lo, out_hi;
  int                        accum;
  int                        last_err;
  logic signed [WORD_W-1:0]  due_drive[$];

  initial begin
    mismatches = 0;
    pending    = 0;
  end

  task automatic flag(input string what, input logic signed [WORD_W-1:0] want,
                      input logic signed [WORD_W-1:0] got);
    $display("%0t: %s: expected %0d, got %0d", $realtime, what, want, got);
    mismatches++;
  endtask

  function automatic logic signed [WORD_W-1:0] next_drive(
    input logic signed [15:0] tgt, input logic signed [15:0] meas);
    longint                    err, acc, lim;
    logic signed [WORD_W-1:0]  iprod, iterm, dterm, total, gained;
    err   = longint'(tgt) - longint'(meas);
    iprod = 32'(longint'(ki) * (err + longint'(accum)));
    iterm = iprod >>> ISHIFT;
    acc   = longint'(accum) + err;
    lim   = longint'(i_lim);
    if (acc > lim) begin
      acc = lim;
    end else if (acc < -lim) begin
      acc = -lim;
    end
    accum    = int'(acc);
    dterm    = 32'(longint'(kd) * (err - longint'(last_err)));
    last_err = int'(err);
    total    = 32'(err + longint'(iterm) + longint'(dterm));
    gained   = 32'(longint'(kp) * longint'(total));
    // upper bound is tested first, so it wins for values above it when the bounds are crossed
    if (gained > out_hi) begin
      gained = out_hi;
    end else if (gained < out_lo) begin
      gained = out_lo;
    end
    return gained;
  endfunction

  always @(posedge clk) begin
    logic signed [WORD_W-1:0] want;
    if (rst) begin
      kp       = '0;
      ki       = '0;
      kd       = '0;
      i_lim    = I_LIMIT_RST;
      out_lo   = OUT_MIN_RST;
      out_hi   = OUT_MAX_RST;
      accum    = 0;
      last_err = 0;
      due_drive.delete();
    end else begin
      if (r_valid && r_ready) begin
        if (due_drive.size() == 0) begin
          flag("drive beat with nothing pending", '0, r_drive);
        end else begin
          want = due_drive.pop_front();
          if (r_drive !== want) begin
            flag("drive mismatch", want, r_drive);
          end
        end
      end
      if (c_valid && c_ready) begin
        case (c_index)
          REG_P_GAIN:  kp = c_data[GAIN_W-1:0];
          REG_I_GAIN:  ki = c_data[GAIN_W-1:0];
          REG_D_GAIN:  kd = c_data[GAIN_W-1:0];
          REG_I_LIMIT: i_lim = c_data[LIMIT_W-1:0];
          REG_OUT_MIN: out_lo = c_data;
          REG_OUT_MAX: out_hi = c_data;
          default: ;
        endcase
      end
      if (s_valid && s_ready) begin
        due_drive.push_back(next_drive(s_target, s_measured));
      end
    end
    pending = due_drive.size();
  end

endmodule

FILE: sim/pid_controller_step_tb.sv
// top of the pid controller step testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module pid_controller_step_tb;
  import pcs_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;
  localparam logic [WORD_W-1:0]    WORD_MIN    = 32'h8000_0000;
  localparam logic [WORD_W-1:0]    WORD_MAX    = 32'h7fff_ffff;
  localparam logic [LIMIT_W-1:0]   LIMIT_MAX   = 30'h3fff_ffff;
  localparam int                   PHASES      = 6;
  localparam int                   PHASE_ITEMS = 255;

  logic clk = 1'b0;
  logic rst;
  bit   calm;
  int   mismatches;
  int   pending;

  pcs_sample_if #(.W(INPUT_BITS_DEF)) smp_if ();
  pcs_result_if res_if ();
  pcs_cfg_if    cfg_if ();

  pid_controller_step dut (
    .clk    (clk),
    .rst    (rst),
    .sample (smp_if),
    .result (res_if),
    .cfg    (cfg_if)
  );

  pcs_drive_checker chk (
    .clk        (clk),
    .rst        (rst),
    .s_valid    (smp_if.valid),
    .s_ready    (smp_if.ready),
    .s_target   (smp_if.target),
    .s_measured (smp_if.measured),
    .r_valid    (res_if.valid),
    .r_ready    (res_if.ready),
    .r_drive    (res_if.drive),
    .c_valid    (cfg_if.valid),
    .c_ready    (cfg_if.ready),
    .c_index    (cfg_if.index),
    .c_data     (cfg_if.data),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always #4 clk = ~clk;

  always @(negedge clk) begin
    res_if.ready <= calm || ($urandom_range(0, 99) >= 7);
  end

  initial begin
    #5ms;
    $display("pid_controller_step_tb: FAIL");
    $finish;
  end

  task automatic send(input logic [15:0] tgt, input logic [15:0] meas);
    if (!calm && $urandom_range(0, 99) < 7) begin
      smp_if.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    smp_if.valid    <= 1'b1;
    smp_if.target   <= tgt;
    smp_if.measured <= meas;
    do @(posedge clk); while (!(smp_if.valid && smp_if.ready));
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk); while (!(cfg_if.valid && cfg_if.ready));
    @(negedge clk);
  endtask

  // stop sending and wait for every drive beat still owed
  task automatic drain;
    smp_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic set_all(input logic [15:0] p, input logic [15:0] i, input logic [15:0] d,
                         input logic [LIMIT_W-1:0] lim, input logic [WORD_W-1:0] lo,
                         input logic [WORD_W-1:0] hi);
    write_reg(REG_P_GAIN, {16'h0, p});
    write_reg(REG_I_GAIN, {16'h0, i});
    write_reg(REG_D_GAIN, {16'h0, d});
    write_reg(REG_I_LIMIT, {2'b00, lim});
    write_reg(REG_OUT_MIN, lo);
    write_reg(REG_OUT_MAX, hi);
    cfg_if.valid <= 1'b0;
  endtask

  function automatic logic [15:0] pick_gain();
    case ($urandom_range(0, 5))
      0:       return 16'h0000;
      1:       return 16'hffff;
      2:       return 16'($urandom_range(1, 8));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_config;
    logic [LIMIT_W-1:0] lim;
    int                 a, b, w, lo, hi;
    case ($urandom_range(0, 3))
      0:       lim = '0;
      1:       lim = LIMIT_MAX;
      2:       lim = 30'($urandom_range(1, 1000));
      default: lim = 30'($urandom);
    endcase
    a = $urandom;
    b = $urandom;
    case ($urandom_range(0, 4))
      0: begin
        lo = WORD_MIN;
        hi = WORD_MAX;
      end
      1: begin
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
      end
      2: begin
        lo = (a < b) ? b : a;
        hi = (a < b) ? a : b;
      end
      3: begin
        lo = WORD_MAX;
        hi = WORD_MIN;
      end
      default: begin
        w  = $urandom_range(0, 5000);
        lo = -w;
        hi = w;
      end
    endcase
    if ($urandom_range(0, 1) == 1) begin
      write_reg(($urandom_range(0, 1) == 1) ? REG_SPARE_A : REG_SPARE_B, $urandom);
    end
    set_all(pick_gain(), pick_gain(), pick_gain(), lim, lo, hi);
  endtask

  task automatic random_sample;
    logic [15:0] tgt, meas;
    tgt = 16'($urandom);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: meas = 16'($urandom);
      4, 5, 6, 7: meas = tgt + 16'($urandom_range(0, 128)) - 16'd64;
      8: begin
        tgt  = ($urandom_range(0, 1) == 1) ? 16'h7fff : 16'h8000;
        meas = ($urandom_range(0, 1) == 1) ? 16'h7fff : 16'h8000;
      end
      default: begin
        tgt  = 16'($urandom_range(0, 3));
        meas = 16'($urandom_range(0, 3));
      end
    endcase
    send(tgt, meas);
  endtask

  initial begin
    rst             = 1'b1;
    calm            = 1'b0;
    smp_if.valid    = 1'b0;
    smp_if.target   = '0;
    smp_if.measured = '0;
    cfg_if.valid    = 1'b0;
    cfg_if.index    = '0;
    cfg_if.data     = '0;
    res_if.ready    = 1'b0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset gains give zero drive
    send(16'd100, -16'sd100);
    send(16'h7fff, 16'h8000);

    drain();
    set_all(16'd1, 16'd1, 16'd1, LIMIT_MAX, WORD_MIN, WORD_MAX);
    send(16'h7fff, 16'h8000);
    send(16'h7fff, 16'h8000);
    send(16'h7fff, 16'h8000);
    send(16'h8000, 16'h7fff);
    send(16'h8000, 16'h7fff);
    send(16'h0000, 16'h0000);

    // accumulator left above a lowered limit; spare indexes must be ignored
    drain();
    write_reg(REG_SPARE_A, 32'hffff_ffff);
    write_reg(REG_SPARE_B, 32'hffff_ffff);
    write_reg(REG_I_LIMIT, 32'd5);
    cfg_if.valid <= 1'b0;
    send(16'd0, 16'd0);
    send(16'd10, 16'd0);

    // wrapping products at full gain
    drain();
    set_all(16'hffff, 16'hffff, 16'hffff, LIMIT_MAX, WORD_MIN, WORD_MAX);
    send(16'h7fff, 16'h8000);
    send(16'h8000, 16'h7fff);
    send(16'd12345, -16'sd20000);

    // crossed output bounds
    drain();
    set_all(16'd3, 16'd0, 16'd0, LIMIT_MAX, 32'sd1000, -32'sd1000);
    send(16'd1000, 16'd0);
    send(16'd0, 16'd0);
    send(-16'sd1000, 16'd0);

    drain();
    set_all(16'd1, 16'd4, 16'd2, 30'd200, -32'sd50, 32'sd50);
    send(16'd30, 16'd0);
    send(-16'sd30, 16'd0);
    send(16'd5, 16'd7);

    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      calm <= (ph == 3);
      random_config();
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 1 && n == 100) begin
          drain();
        end
        random_sample();
      end
    end

    drain();
    repeat (16) @(negedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("pid_controller_step_tb: PASS");
    end else begin
      $display("pid_controller_step_tb: FAIL");
    end
    $finish;
  end

endmodule
